// ===== hw/rtl/pfpc_pkg.sv =====
// Shared types, field widths and codes for the polygon fill pixel classifier.
package pfpc_pkg;

    localparam int IN_COORD_W  = 16;
    localparam int SLOT_W      = 3;
    localparam int COLOR_W     = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int VCOUNT_W    = 4;
    localparam int THICK_W     = 10;
    localparam int IMG_W       = 15;
    localparam int SQ_K_W      = 19;
    localparam int MIN_VERTICES = 3;

    typedef logic signed [IN_COORD_W-1:0] coord_t;
    typedef logic [SLOT_W-1:0]            slot_t;
    typedef logic [COLOR_W-1:0]           color_t;
    typedef logic [CFG_INDEX_W-1:0]       cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]        cfg_data_t;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    localparam cfg_index_t REG_VERTEX_COUNT     = 3'd0;
    localparam cfg_index_t REG_BORDER_THICKNESS = 3'd1;
    localparam cfg_index_t REG_IMAGE_WIDTH      = 3'd2;
    localparam cfg_index_t REG_IMAGE_HEIGHT     = 3'd3;
    localparam cfg_index_t REG_FILL_COLOR       = 3'd4;

endpackage

// ===== hw/rtl/pfpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pfpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/polygon_fill_pixel_classifier.sv =====
// Polygon fill pixel classifier: vertex store, edge sequencer and shared multiplier.
//
// Input beats carry a command: a load writes one vertex into the store at slot,
// a test classifies the pixel (coord_x, coord_y) against the closed polygon made
// of the first vertex_count vertices (clamped to 3..MAX_VERTICES).
// Every input beat yields exactly one output beat; a load answers all zeros.
// Each test walks the edges one at a time through a single signed multiplier:
// eleven products per edge plus load and evaluate steps.
// in_ready is high only while the sequencer is idle; a finished result sits in
// the output register, so the next beat is accepted while it waits.
// If the receiver stalls and the output register is still full when the next
// result is done, the sequencer holds until the register frees.
// Configuration writes are registered; the user must make them only while idle (not enforced).
// Reset loads the register defaults and empties the output; vertex store
// contents are undefined until loaded.
module polygon_fill_pixel_classifier #(
    parameter int MAX_VERTICES = 8,
    parameter int COORD_BITS   = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  pfpc_pkg::slot_t      slot,
    input  pfpc_pkg::coord_t     coord_x,
    input  pfpc_pkg::coord_t     coord_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 paint,
    output logic                 on_border,
    output logic                 is_inside,
    output pfpc_pkg::color_t     pixel_color,
    input  logic                 cfg_write,
    input  pfpc_pkg::cfg_index_t cfg_index,
    input  pfpc_pkg::cfg_data_t  cfg_data
);
    import pfpc_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int IW = $clog2(MAX_VERTICES);
    localparam int DW = ((C > IN_COORD_W) ? C : IN_COORD_W) + 1;
    localparam int MW = ((DW > SQ_K_W) ? DW : SQ_K_W) + 1;
    localparam int PW = 2 * MW;
    localparam int AW = 4 * DW;
    localparam int SW = 4;

    localparam logic [7:0] MAXV8 = 8'(MAX_VERTICES);
    localparam logic [7:0] MINV8 = 8'(MIN_VERTICES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRIME = 3'd1;
    localparam logic [2:0] S_LOADI = 3'd2;
    localparam logic [2:0] S_LOADJ = 3'd3;
    localparam logic [2:0] S_EDGE  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [SW-1:0] STEP_DXDX = 4'd0;
    localparam logic [SW-1:0] STEP_DYDY = 4'd1;
    localparam logic [SW-1:0] STEP_DXRX = 4'd2;
    localparam logic [SW-1:0] STEP_DYRY = 4'd3;
    localparam logic [SW-1:0] STEP_DYRX = 4'd4;
    localparam logic [SW-1:0] STEP_DXRY = 4'd5;
    localparam logic [SW-1:0] STEP_KLH  = 4'd6;
    localparam logic [SW-1:0] STEP_KLL  = 4'd7;
    localparam logic [SW-1:0] STEP_HH   = 4'd8;
    localparam logic [SW-1:0] STEP_HL   = 4'd9;
    localparam logic [SW-1:0] STEP_LL   = 4'd10;
    localparam logic [SW-1:0] STEP_TAIL = 4'd11;
    localparam logic [SW-1:0] STEP_EVAL = 4'd12;

    // control
    logic [2:0]          state_reg, state_next;
    logic [SW-1:0]       st_reg, st_next;
    logic [IW-1:0]       edge_reg, edge_next;
    logic                out_valid_reg, out_valid_next;
    logic [VCOUNT_W-1:0] vcount_reg, vcount_next;
    logic [THICK_W-1:0]  thick_reg, thick_next;
    logic [IMG_W-1:0]    width_reg, width_next;
    logic [IMG_W-1:0]    height_reg, height_next;
    color_t              color_reg, color_next;

    // datapath
    coord_t               px_reg, px_next, py_reg, py_next;
    logic [IW-1:0]        nlast_reg, nlast_next;
    logic                 is_test_reg, is_test_next;
    logic                 inside_reg, inside_next, border_reg, border_next;
    logic signed [C-1:0]  xi_reg, xi_next, yi_reg, yi_next;
    logic signed [C-1:0]  xj_reg, xj_next, yj_reg, yj_next;
    logic signed [C-1:0]  xmin_reg, xmin_next, xmax_reg, xmax_next;
    logic signed [C-1:0]  ymin_reg, ymin_next, ymax_reg, ymax_next;
    logic signed [DW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [DW-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] len2_reg, len2_next, proj_reg, proj_next;
    logic signed [PW-1:0] crs_reg, crs_next, pa_reg, pa_next, num_reg, num_next;
    logic [AW-1:0]        sq_reg, sq_next, thr_reg, thr_next;
    logic [SQ_K_W-1:0]    k_reg, k_next;
    logic                 paint_reg, paint_next;
    logic                 on_border_reg, on_border_next;
    logic                 is_inside_reg, is_inside_next;
    color_t               pixel_color_reg, pixel_color_next;

    // combinational
    logic                 in_fire;
    logic [7:0]           vc8, nsel8;
    logic [IW-1:0]        nlast_w;
    logic                 wr_en;
    logic [2*C-1:0]       rd_data;
    logic signed [C-1:0]  rd_x, rd_y;
    logic [IW-1:0]        rd_addr, jnext;
    logic signed [MW-1:0] opa, opb;
    logic signed [PW-1:0] prod_w;
    logic [THICK_W-1:0]   hp1;
    logic [PW-1:0]        mag, pu;
    logic [DW-1:0]        mag_hi, mag_lo, len_hi, len_lo;
    logic                 len2_zero, proj_ok, edge_border;
    logic signed [DW-1:0] py_ext, yi_ext, yj_ext, px_ext;
    logic                 straddle, left_of, num_nonpos;
    logic signed [PW-1:0] pady;
    logic                 in_box, in_img, paint_w;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign vc8     = 8'(vcount_reg);
    assign nsel8   = (vc8 < MINV8) ? MINV8 : ((vc8 > MAXV8) ? MAXV8 : vc8);
    assign nlast_w = IW'(nsel8 - 8'd1);

    assign wr_en = in_fire && (cmd == CMD_LOAD) && (8'(slot) < MAXV8);

    assign jnext = (edge_reg + IW'(1) == nlast_reg) ? '0 : edge_reg + IW'(2);

    always_comb
    begin
        case (state_reg)
            S_PRIME: rd_addr = '0;
            S_LOADI: rd_addr = IW'(1);
            default: rd_addr = jnext;
        endcase
    end

    pfpc_ram #(
        .WIDTH (2 * C),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (IW'(slot)),
        .wr_data ({C'(coord_x), C'(coord_y)}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_x = rd_data[2*C-1:C];
    assign rd_y = rd_data[C-1:0];

    assign hp1    = THICK_W'(thick_reg >> 1) + THICK_W'(1);
    assign mag    = crs_reg[PW-1] ? -crs_reg : crs_reg;
    assign mag_hi = mag[2*DW-1:DW];
    assign mag_lo = mag[DW-1:0];
    assign len_hi = len2_reg[2*DW-1:DW];
    assign len_lo = len2_reg[DW-1:0];
    assign pu     = prod_reg;

    always_comb
    begin
        opa = '0;
        opb = '0;
        if (state_reg == S_PRIME)
        begin
            opa = MW'(hp1);
            opb = MW'(hp1);
        end
        else if (state_reg == S_EDGE)
        begin
            case (st_reg)
                STEP_DXDX: begin opa = MW'(dx_reg); opb = MW'(dx_reg); end
                STEP_DYDY: begin opa = MW'(dy_reg); opb = MW'(dy_reg); end
                STEP_DXRX: begin opa = MW'(dx_reg); opb = MW'(rx_reg); end
                STEP_DYRY: begin opa = MW'(dy_reg); opb = MW'(ry_reg); end
                STEP_DYRX: begin opa = MW'(dy_reg); opb = MW'(rx_reg); end
                STEP_DXRY: begin opa = MW'(dx_reg); opb = MW'(ry_reg); end
                STEP_KLH:  begin opa = MW'(k_reg);  opb = MW'(len_hi); end
                STEP_KLL:  begin opa = MW'(k_reg);  opb = MW'(len_lo); end
                STEP_HH:   begin opa = MW'(mag_hi); opb = MW'(mag_hi); end
                STEP_HL:   begin opa = MW'(mag_hi); opb = MW'(mag_lo); end
                STEP_LL:   begin opa = MW'(mag_lo); opb = MW'(mag_lo); end
                default:   begin opa = '0; opb = '0; end
            endcase
        end
    end

    assign prod_w = opa * opb;

    // per-edge evaluation
    assign len2_zero   = (len2_reg == '0);
    assign proj_ok     = !proj_reg[PW-1] && (proj_reg <= len2_reg);
    assign edge_border = len2_zero ? ((rx_reg == '0) && (ry_reg == '0))
                                   : (proj_ok && (sq_reg < thr_reg));
    assign py_ext      = DW'(py_reg);
    assign yi_ext      = DW'(yi_reg);
    assign yj_ext      = DW'(yj_reg);
    assign straddle    = (yi_ext > py_ext) != (yj_ext > py_ext);
    assign pady        = pa_reg + PW'(dy_reg);
    assign num_nonpos  = num_reg[PW-1] || (num_reg == '0);
    assign left_of     = dy_reg[DW-1]
                       ? (num_nonpos ? (pady >= num_reg) : (pa_reg > num_reg))
                       : (!num_reg[PW-1] ? (pady <= num_reg) : (pa_reg < num_reg));

    // final classification
    assign px_ext  = DW'(px_reg);
    assign in_box  = (px_ext >= DW'(xmin_reg)) && (px_ext <= DW'(xmax_reg))
                  && (py_ext >= DW'(ymin_reg)) && (py_ext <= DW'(ymax_reg));
    assign in_img  = !px_reg[IN_COORD_W-1] && !py_reg[IN_COORD_W-1]
                  && (px_reg[IMG_W-1:0] < width_reg) && (py_reg[IMG_W-1:0] < height_reg);
    assign paint_w = is_test_reg && inside_reg && !border_reg && in_box && in_img;

    always_comb
    begin
        state_next       = state_reg;
        st_next          = st_reg;
        edge_next        = edge_reg;
        out_valid_next   = out_valid_reg;
        vcount_next      = vcount_reg;
        thick_next       = thick_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        color_next       = color_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        nlast_next       = nlast_reg;
        is_test_next     = is_test_reg;
        inside_next      = inside_reg;
        border_next      = border_reg;
        xi_next          = xi_reg;
        yi_next          = yi_reg;
        xj_next          = xj_reg;
        yj_next          = yj_reg;
        xmin_next        = xmin_reg;
        xmax_next        = xmax_reg;
        ymin_next        = ymin_reg;
        ymax_next        = ymax_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        rx_next          = rx_reg;
        ry_next          = ry_reg;
        len2_next        = len2_reg;
        proj_next        = proj_reg;
        crs_next         = crs_reg;
        pa_next          = pa_reg;
        num_next         = num_reg;
        sq_next          = sq_reg;
        thr_next         = thr_reg;
        k_next           = k_reg;
        paint_next       = paint_reg;
        on_border_next   = on_border_reg;
        is_inside_next   = is_inside_reg;
        pixel_color_next = pixel_color_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_VERTEX_COUNT:     vcount_next = cfg_data[VCOUNT_W-1:0];
                REG_BORDER_THICKNESS: thick_next  = cfg_data[THICK_W-1:0];
                REG_IMAGE_WIDTH:      width_next  = cfg_data[IMG_W-1:0];
                REG_IMAGE_HEIGHT:     height_next = cfg_data[IMG_W-1:0];
                REG_FILL_COLOR:       color_next  = cfg_data[COLOR_W-1:0];
                default:              ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    px_next      = coord_x;
                    py_next      = coord_y;
                    nlast_next   = nlast_w;
                    is_test_next = (cmd == CMD_TEST);
                    inside_next  = 1'b0;
                    border_next  = 1'b0;
                    edge_next    = '0;
                    st_next      = '0;
                    state_next   = (cmd == CMD_TEST) ? S_PRIME : S_DONE;
                end
            end
            S_PRIME:
            begin
                state_next = S_LOADI;
            end
            S_LOADI:
            begin
                k_next     = SQ_K_W'(pu);
                xi_next    = rd_x;
                yi_next    = rd_y;
                xmin_next  = rd_x;
                xmax_next  = rd_x;
                ymin_next  = rd_y;
                ymax_next  = rd_y;
                state_next = S_LOADJ;
            end
            S_LOADJ:
            begin
                xj_next = rd_x;
                yj_next = rd_y;
                dx_next = DW'(rd_x) - DW'(xi_reg);
                dy_next = DW'(rd_y) - DW'(yi_reg);
                rx_next = DW'(px_reg) - DW'(xi_reg);
                ry_next = DW'(py_reg) - DW'(yi_reg);
                if (xi_reg < xmin_reg) xmin_next = xi_reg;
                if (xi_reg > xmax_reg) xmax_next = xi_reg;
                if (yi_reg < ymin_reg) ymin_next = yi_reg;
                if (yi_reg > ymax_reg) ymax_next = yi_reg;
                st_next    = '0;
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                st_next = st_reg + SW'(1);
                // accumulate the product issued on the previous step
                case (st_reg)
                    STEP_DYDY: len2_next = prod_reg;
                    STEP_DXRX: len2_next = len2_reg + prod_reg;
                    STEP_DYRY: proj_next = prod_reg;
                    STEP_DYRX: proj_next = proj_reg + prod_reg;
                    STEP_DXRY:
                    begin
                        crs_next = prod_reg;
                        pa_next  = prod_reg;
                    end
                    STEP_KLH:
                    begin
                        num_next = prod_reg;
                        crs_next = crs_reg - prod_reg;
                    end
                    STEP_KLL:  thr_next = AW'(pu);
                    STEP_HH:   thr_next = (thr_reg << DW) + AW'(pu);
                    STEP_HL:   sq_next  = AW'(pu);
                    STEP_LL:   sq_next  = (sq_reg << DW) + (AW'(pu) << 1);
                    STEP_TAIL: sq_next  = (sq_reg << DW) + AW'(pu);
                    default:   ;
                endcase
                if (st_reg == STEP_EVAL)
                begin
                    border_next = border_reg || edge_border;
                    if (straddle && left_of)
                    begin
                        inside_next = !inside_reg;
                    end
                    if (edge_reg == nlast_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        edge_next  = edge_reg + IW'(1);
                        xi_next    = xj_reg;
                        yi_next    = yj_reg;
                        state_next = S_LOADJ;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    paint_next       = paint_w;
                    on_border_next   = border_reg;
                    is_inside_next   = inside_reg;
                    pixel_color_next = paint_w ? color_reg : '0;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            st_reg        <= '0;
            edge_reg      <= '0;
            out_valid_reg <= 1'b0;
            vcount_reg    <= VCOUNT_W'(4);
            thick_reg     <= THICK_W'(1);
            width_reg     <= IMG_W'(640);
            height_reg    <= IMG_W'(480);
            color_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            edge_reg      <= edge_next;
            out_valid_reg <= out_valid_next;
            vcount_reg    <= vcount_next;
            thick_reg     <= thick_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            color_reg     <= color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg          <= px_next;
        py_reg          <= py_next;
        nlast_reg       <= nlast_next;
        is_test_reg     <= is_test_next;
        inside_reg      <= inside_next;
        border_reg      <= border_next;
        xi_reg          <= xi_next;
        yi_reg          <= yi_next;
        xj_reg          <= xj_next;
        yj_reg          <= yj_next;
        xmin_reg        <= xmin_next;
        xmax_reg        <= xmax_next;
        ymin_reg        <= ymin_next;
        ymax_reg        <= ymax_next;
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        rx_reg          <= rx_next;
        ry_reg          <= ry_next;
        prod_reg        <= prod_w;
        len2_reg        <= len2_next;
        proj_reg        <= proj_next;
        crs_reg         <= crs_next;
        pa_reg          <= pa_next;
        num_reg         <= num_next;
        sq_reg          <= sq_next;
        thr_reg         <= thr_next;
        k_reg           <= k_next;
        paint_reg       <= paint_next;
        on_border_reg   <= on_border_next;
        is_inside_reg   <= is_inside_next;
        pixel_color_reg <= pixel_color_next;
    end

    assign out_valid   = out_valid_reg;
    assign paint       = paint_reg;
    assign on_border   = on_border_reg;
    assign is_inside   = is_inside_reg;
    assign pixel_color = pixel_color_reg;

    a_paint_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && paint |-> is_inside && !on_border)
        else $error("painted pixel is outside or on the border");

    a_color_gated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !paint |-> pixel_color == '0)
        else $error("color driven on an unpainted pixel");

    a_test_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cmd == CMD_TEST |=> !in_ready && state_reg == S_PRIME)
        else $error("test beat did not start the edge walk");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EDGE |-> edge_reg <= nlast_reg && st_reg <= STEP_EVAL)
        else $error("edge walk ran past the last edge or step");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && (!out_valid || out_ready) |=> out_valid && in_ready)
        else $error("finished result not delivered to the output register");

endmodule
